@@ rtl/core/mkpp_pkg.sv @@
// Shared types and constants of the key position predictor.
// Holds the command and register codes, the controller-to-datapath command and
// status structs, and the constant log2 interpolation table. No dependencies.
package mkpp_pkg;

    localparam int COEFF_W    = 32;
    localparam int KEY_W      = 32;
    localparam int OFFSET_W   = 56;
    localparam int SCALE_W    = 48;
    localparam int PSCALE_W   = 32;
    localparam int CFG_W      = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int ACC_W      = 60;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;
    localparam int TAB_W      = 25;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 32;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef enum logic [1:0] {
        CMD_WEIGHT  = 2'd0,
        CMD_BIAS    = 2'd1,
        CMD_PREDICT = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG_MODE       = 2'd0,
        REG_KEY_OFFSET     = 2'd1,
        REG_KEY_SCALE      = 2'd2,
        REG_POSITION_SCALE = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_KEY_LOAD,
        DP_LOG_SHIFT,
        DP_LOG_LUT,
        DP_LOG_SUM,
        DP_LOG_T,
        DP_NORM_SUB,
        DP_NORM_M1,
        DP_NORM_M2,
        DP_NORM_M3,
        DP_NORM_M4,
        DP_NORM_FIN,
        DP_BIAS_LD,
        DP_ACT_WB,
        DP_POS_MUL,
        DP_POS_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   mac_issue;
        logic   out_load;
        logic   last_layer;
    } dp_cmd_t;

    typedef struct packed {
        logic log_mode;
        logic v_top;
        logic out_busy;
    } dp_status_t;

    typedef logic [TAB_W-1:0] log_tab_t [0:256];

    // Entry i is log2(1 + i/256) in Q1.24, found by repeated squaring on Q2.30.
    function automatic log_tab_t build_log_tab();
        log_tab_t    tab;
        logic [63:0] x;
        logic [63:0] r;
        for (int i = 0; i < 256; i++) begin
            x = 64'(256 + i) << 22;
            r = '0;
            for (int k = 0; k < 28; k++) begin
                x = (x * x) >> 30;
                r = r << 1;
                if (x >= (64'd2 << 30)) begin
                    r[0] = 1'b1;
                    x    = x >> 1;
                end
            end
            tab[i] = TAB_W'((r + 64'd8) >> 4);
        end
        tab[256] = TAB_W'(1) << 24;
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

@@ rtl/core/mkpp_datapath.sv @@
// Datapath of the key position predictor: configuration registers, weight, bias
// and activation memories, the shared multiplier, accumulator and output register.
// Depends on mkpp_pkg; driven by mkpp_ctrl.
module mkpp_datapath
    import mkpp_pkg::*;
#(
    parameter int HIDDEN = 16,
    parameter int LAYERS = 3,
    parameter int LAY_W  = $clog2(LAYERS + 1),
    parameter int IDX_W  = $clog2(HIDDEN + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_fire,
    input  cmd_t                     in_cmd,
    input  logic [2:0]               in_layer,
    input  logic [5:0]               in_from,
    input  logic [5:0]               in_to,
    input  logic [COEFF_W-1:0]       in_coeff,
    input  logic [KEY_W-1:0]         in_key,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  dp_cmd_t                  cmd,
    input  logic [LAY_W-1:0]         layer,
    input  logic [IDX_W-1:0]         idx_i,
    input  logic [IDX_W-1:0]         idx_j,
    output dp_status_t               status,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [31:0]              out_position,
    output logic                     out_saturated
);

    localparam int WMEM_SIZE = (LAYERS == 1) ? 1 : 2 * HIDDEN + (LAYERS - 2) * HIDDEN * HIDDEN;
    localparam int BMEM_SIZE = (LAYERS - 1) * HIDDEN + 1;
    localparam int WADDR_W   = $clog2(WMEM_SIZE + 1);
    localparam int BADDR_W   = $clog2(BMEM_SIZE + 1);
    localparam int ACT_SIZE  = 2 * HIDDEN;
    localparam int ACT_AW    = $clog2(ACT_SIZE);

    localparam logic signed [ACC_W-1:0] ACC_MAX   = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ACC_MIN   = ACC_W'(-64'sd2147483648);
    localparam logic signed [ACC_W-1:0] ACC_TWO31 = ACC_W'(64'sd2147483648);
    localparam logic signed [ACC_W-1:0] ACC_TWO40 = ACC_W'(64'sd1099511627776);

    function automatic logic [WADDR_W-1:0] w_addr(input logic [LAY_W-1:0] l,
                                                  input logic last, input logic [5:0] src,
                                                  input logic [5:0] dst);
        logic [WADDR_W-1:0] base;
        logic [WADDR_W-1:0] row;
        if (l == '0) begin
            base = '0;
        end else begin
            base = WADDR_W'(HIDDEN) + WADDR_W'(l - LAY_W'(1)) * WADDR_W'(HIDDEN * HIDDEN);
        end
        row = last ? WADDR_W'(src) : WADDR_W'(src) * WADDR_W'(HIDDEN);
        return base + row + WADDR_W'(dst);
    endfunction

    function automatic logic [BADDR_W-1:0] b_addr(input logic [LAY_W-1:0] l,
                                                  input logic [5:0] dst);
        return BADDR_W'(l) * BADDR_W'(HIDDEN) + BADDR_W'(dst);
    endfunction

    function automatic logic [ACT_AW-1:0] act_addr(input logic bank, input logic [5:0] dst);
        return ACT_AW'(bank) * ACT_AW'(HIDDEN) + ACT_AW'(dst);
    endfunction

    logic [COEFF_W-1:0] weight_mem [WMEM_SIZE];
    logic [COEFF_W-1:0] bias_mem [BMEM_SIZE];
    logic [31:0]        act_mem [ACT_SIZE];

    logic                       log_mode_reg;
    logic [OFFSET_W-1:0]        key_offset_reg;
    logic [SCALE_W-1:0]         key_scale_reg;
    logic [PSCALE_W-1:0]        pos_scale_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       out_valid_reg;

    logic [KEY_W-1:0]           key_reg;
    logic [32:0]                v_reg;
    logic [5:0]                 p_reg;
    logic [OFFSET_W-1:0]        t_reg;
    logic [30:0]                base_reg;
    logic                       neg_reg;
    logic                       big_reg;
    logic [OFFSET_W-1:0]        mag_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [31:0]         y_reg;
    logic                       sat_reg;
    logic [COEFF_W-1:0]         w_rd_reg;
    logic [COEFF_W-1:0]         b_rd_reg;
    logic [31:0]                a_rd_reg;
    logic [31:0]                pos_reg;
    logic                       osat_reg;

    logic [2:0]                 wl_wide;
    logic [LAY_W-1:0]           wl;
    logic                       wl_last;
    logic                       wr_ok;
    logic                       w_we;
    logic                       b_we;
    logic [WADDR_W-1:0]         w_waddr;
    logic [BADDR_W-1:0]         b_waddr;
    logic [WADDR_W-1:0]         r_waddr;
    logic [BADDR_W-1:0]         r_baddr;
    logic [ACT_AW-1:0]          r_aaddr;
    logic                       act_we;
    logic [ACT_AW-1:0]          act_waddr;
    logic [31:0]                act_wdata;

    logic [7:0]                 lut_idx;
    logic [TAB_W-1:0]           lut_t0;
    logic [TAB_W-1:0]           lut_t1;
    logic [TAB_W-1:0]           lut_dt;
    logic [30:0]                l2;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_r31;
    logic signed [PROD_W-1:0]   prod_r23;
    logic signed [ACC_W-1:0]    mac_term;
    logic                       t_neg;
    logic [OFFSET_W-1:0]        t_mag;
    logic signed [ACC_W-1:0]    norm_r;
    logic [31:0]                norm_x;
    logic                       norm_clip;
    logic [31:0]                hid_x;
    logic                       hid_clip;
    logic [31:0]                last_y;
    logic                       last_clip;
    logic [31:0]                pos_x;
    logic                       pos_clip;

    // Write decode for weight and bias requests, and read addresses of the memories.
    always_comb
    begin
        wl_wide = in_layer;
        wl      = LAY_W'(wl_wide);
        wl_last = (wl == LAY_W'(LAYERS - 1));
        wr_ok   = ({1'b0, in_layer} < 4'(LAYERS)) &&
                  (wl_last ? (in_to == '0) : ({1'b0, in_to} < 7'(HIDDEN)));
        w_we    = in_fire && (in_cmd == CMD_WEIGHT) && wr_ok &&
                  ((wl == '0) ? (in_from == '0) : ({1'b0, in_from} < 7'(HIDDEN)));
        b_we    = in_fire && (in_cmd == CMD_BIAS) && wr_ok;
        w_waddr = w_addr(wl, wl_last, in_from, in_to);
        b_waddr = b_addr(wl, in_to);
        r_waddr = w_addr(layer, cmd.last_layer, 6'(idx_i), 6'(idx_j));
        r_baddr = b_addr(layer, 6'(idx_j));
        r_aaddr = act_addr(layer[0], 6'(idx_i));
    end

    // Logarithm, multiplier operands and rounding.
    always_comb
    begin
        lut_idx  = v_reg[31:24];
        lut_t0   = LOG_TAB[lut_idx];
        lut_t1   = LOG_TAB[9'(lut_idx) + 9'd1];
        lut_dt   = lut_t1 - lut_t0;
        l2       = base_reg + 31'(prod_reg[47:24]);
        mul_a    = '0;
        mul_b    = '0;
        if (v1_reg) begin
            mul_a = MUL_W'($signed(a_rd_reg));
            mul_b = MUL_W'($signed(w_rd_reg));
        end else begin
            case (cmd.op)
                DP_LOG_LUT:
                begin
                    mul_a = $signed(MUL_W'(lut_dt));
                    mul_b = $signed(MUL_W'(v_reg[23:0]));
                end
                DP_LOG_SUM:
                begin
                    mul_a = $signed(MUL_W'(l2));
                    mul_b = $signed(MUL_W'(LN2_Q32));
                end
                DP_NORM_M1:
                begin
                    mul_a = $signed(MUL_W'(mag_reg[31:0]));
                    mul_b = $signed(MUL_W'(key_scale_reg[31:0]));
                end
                DP_NORM_M2:
                begin
                    mul_a = $signed(MUL_W'(mag_reg[31:0]));
                    mul_b = $signed(MUL_W'(key_scale_reg[47:32]));
                end
                DP_NORM_M3:
                begin
                    mul_a = $signed(MUL_W'(mag_reg[55:32]));
                    mul_b = $signed(MUL_W'(key_scale_reg[31:0]));
                end
                DP_POS_MUL, DP_POS_FIN:
                begin
                    mul_a = MUL_W'(y_reg);
                    mul_b = $signed(MUL_W'(pos_scale_reg));
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        prod_next = mul_a * mul_b;
        prod_r31  = prod_reg + PROD_W'(64'sd2147483648);
        prod_r23  = (prod_reg + PROD_W'(64'sd8388608)) >>> 24;
        mac_term  = ACC_W'(prod_r23);
        t_neg     = t_reg < key_offset_reg;
        t_mag     = t_neg ? key_offset_reg - t_reg : t_reg - key_offset_reg;
    end

    // Saturation of the normalized key, activations and position, and the activation write select.
    always_comb
    begin
        norm_r    = big_reg ? ACC_TWO40 : acc_reg;
        norm_clip = 1'b0;
        if (!neg_reg) begin
            if (norm_r > ACC_MAX) begin
                norm_clip = 1'b1;
                norm_x    = 32'h7FFFFFFF;
            end else begin
                norm_x = norm_r[31:0];
            end
        end else begin
            if (norm_r > ACC_TWO31) begin
                norm_clip = 1'b1;
                norm_x    = 32'h80000000;
            end else begin
                norm_x = 32'(-norm_r);
            end
        end
        hid_clip = acc_reg > ACC_MAX;
        if (acc_reg < 0) begin
            hid_x = '0;
        end else if (hid_clip) begin
            hid_x = 32'h7FFFFFFF;
        end else begin
            hid_x = acc_reg[31:0];
        end
        last_clip = (acc_reg > ACC_MAX) || (acc_reg < ACC_MIN);
        if (acc_reg > ACC_MAX) begin
            last_y = 32'h7FFFFFFF;
        end else if (acc_reg < ACC_MIN) begin
            last_y = 32'h80000000;
        end else begin
            last_y = acc_reg[31:0];
        end
        pos_clip = (prod_r23 > PROD_W'(ACC_MAX)) || (prod_r23 < PROD_W'(ACC_MIN));
        if (prod_r23 > PROD_W'(ACC_MAX)) begin
            pos_x = 32'h7FFFFFFF;
        end else if (prod_r23 < PROD_W'(ACC_MIN)) begin
            pos_x = 32'h80000000;
        end else begin
            pos_x = prod_r23[31:0];
        end
        act_we    = (cmd.op == DP_NORM_FIN) || ((cmd.op == DP_ACT_WB) && !cmd.last_layer);
        act_waddr = (cmd.op == DP_NORM_FIN) ? act_addr(layer[0], 6'(idx_j))
                                            : act_addr(!layer[0], 6'(idx_j));
        act_wdata = (cmd.op == DP_NORM_FIN) ? norm_x : hid_x;
    end

    always_ff @(posedge clk)
    begin
        if (w_we) begin
            weight_mem[w_waddr] <= in_coeff;
        end
        w_rd_reg <= weight_mem[r_waddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we) begin
            bias_mem[b_waddr] <= in_coeff;
        end
        b_rd_reg <= bias_mem[r_baddr];
    end

    always_ff @(posedge clk)
    begin
        if (act_we) begin
            act_mem[act_waddr] <= act_wdata;
        end
        a_rd_reg <= act_mem[r_aaddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            log_mode_reg   <= 1'b0;
            key_offset_reg <= '0;
            key_scale_reg  <= SCALE_W'(64'd4294967296);
            pos_scale_reg  <= PSCALE_W'(1);
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_LOG_MODE:       log_mode_reg   <= cfg_data[0];
                    REG_KEY_OFFSET:     key_offset_reg <= cfg_data[OFFSET_W-1:0];
                    REG_KEY_SCALE:      key_scale_reg  <= cfg_data[SCALE_W-1:0];
                    REG_POSITION_SCALE: pos_scale_reg  <= cfg_data[PSCALE_W-1:0];
                    default:            log_mode_reg   <= log_mode_reg;
                endcase
            end
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (in_fire && (in_cmd == CMD_PREDICT)) begin
            key_reg <= in_key;
        end
        if (v2_reg) begin
            acc_reg <= acc_reg + mac_term;
        end
        case (cmd.op)
            DP_KEY_LOAD:
            begin
                v_reg   <= 33'(key_reg) + 33'd1;
                p_reg   <= 6'd32;
                t_reg   <= {key_reg, 24'b0};
                sat_reg <= 1'b0;
            end
            DP_LOG_SHIFT:
            begin
                if (!v_reg[32]) begin
                    v_reg <= v_reg << 1;
                    p_reg <= p_reg - 6'd1;
                end
            end
            DP_LOG_LUT:
            begin
                base_reg <= 31'({p_reg, 24'b0}) + 31'(lut_t0);
            end
            DP_LOG_T:
            begin
                t_reg <= OFFSET_W'(prod_r31[65:32]);
            end
            DP_NORM_SUB:
            begin
                neg_reg <= t_neg;
                mag_reg <= t_mag;
                big_reg <= (key_scale_reg[47:32] != '0) && (t_mag[55:32] != '0);
            end
            DP_NORM_M2:
            begin
                acc_reg <= $signed(ACC_W'(prod_r31[65:32]));
            end
            DP_NORM_M3, DP_NORM_M4:
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            DP_NORM_FIN:
            begin
                sat_reg <= sat_reg | norm_clip;
            end
            DP_BIAS_LD:
            begin
                acc_reg <= ACC_W'($signed(b_rd_reg));
            end
            DP_ACT_WB:
            begin
                if (cmd.last_layer) begin
                    y_reg   <= $signed(last_y);
                    sat_reg <= sat_reg | last_clip;
                end else begin
                    sat_reg <= sat_reg | hid_clip;
                end
            end
            DP_POS_FIN:
            begin
                if (cmd.out_load) begin
                    pos_reg  <= pos_x;
                    osat_reg <= sat_reg | pos_clip;
                end
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

    assign status.log_mode = log_mode_reg;
    assign status.v_top    = v_reg[32];
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_position    = pos_reg;
    assign out_saturated   = osat_reg;

`ifndef SYNTHESIS
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("A waiting result would be overwritten.");
    a_bias_before_products: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_BIAS_LD) |-> (!v1_reg && !v2_reg))
        else $error("Bias load collides with products in flight.");
    a_writeback_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_ACT_WB) |-> (!v1_reg && !v2_reg))
        else $error("Activation written back before the sum is complete.");
`endif

endmodule

@@ rtl/core/mkpp_ctrl.sv @@
// Controller of the key position predictor: accepts requests and sequences the
// logarithm, normalization, layer loops and output of one prediction.
// Depends on mkpp_pkg; commands mkpp_datapath.
module mkpp_ctrl
    import mkpp_pkg::*;
#(
    parameter int HIDDEN = 16,
    parameter int LAYERS = 3,
    parameter int LAY_W  = $clog2(LAYERS + 1),
    parameter int IDX_W  = $clog2(HIDDEN + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cmd_t             in_cmd,
    input  dp_status_t       status,
    output dp_cmd_t          cmd,
    output logic [LAY_W-1:0] layer,
    output logic [IDX_W-1:0] idx_i,
    output logic [IDX_W-1:0] idx_j
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_KEY,
        S_LSHIFT,
        S_LLUT,
        S_LSUM,
        S_LT,
        S_NSUB,
        S_NM1,
        S_NM2,
        S_NM3,
        S_NM4,
        S_NFIN,
        S_BIAS,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_WB,
        S_PMUL,
        S_PFIN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [LAY_W-1:0] layer_reg;
    logic [LAY_W-1:0] layer_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;
    logic             last_layer;
    logic             last_i;
    logic             last_j;

    always_comb
    begin
        last_layer     = (layer_reg == LAY_W'(LAYERS - 1));
        last_i         = (layer_reg == '0) || (i_reg == IDX_W'(HIDDEN - 1));
        last_j         = last_layer || (j_reg == IDX_W'(HIDDEN - 1));
        state_next     = state_reg;
        layer_next     = layer_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cmd.op         = DP_NOP;
        cmd.mac_issue  = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.last_layer = last_layer;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (in_cmd == CMD_PREDICT)) begin
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                cmd.op     = DP_KEY_LOAD;
                layer_next = '0;
                j_next     = '0;
                state_next = status.log_mode ? S_LSHIFT : S_NSUB;
            end
            S_LSHIFT:
            begin
                cmd.op = DP_LOG_SHIFT;
                if (status.v_top) begin
                    state_next = S_LLUT;
                end
            end
            S_LLUT:
            begin
                cmd.op     = DP_LOG_LUT;
                state_next = S_LSUM;
            end
            S_LSUM:
            begin
                cmd.op     = DP_LOG_SUM;
                state_next = S_LT;
            end
            S_LT:
            begin
                cmd.op     = DP_LOG_T;
                state_next = S_NSUB;
            end
            S_NSUB:
            begin
                cmd.op     = DP_NORM_SUB;
                state_next = S_NM1;
            end
            S_NM1:
            begin
                cmd.op     = DP_NORM_M1;
                state_next = S_NM2;
            end
            S_NM2:
            begin
                cmd.op     = DP_NORM_M2;
                state_next = S_NM3;
            end
            S_NM3:
            begin
                cmd.op     = DP_NORM_M3;
                state_next = S_NM4;
            end
            S_NM4:
            begin
                cmd.op     = DP_NORM_M4;
                state_next = S_NFIN;
            end
            S_NFIN:
            begin
                cmd.op     = DP_NORM_FIN;
                state_next = S_BIAS;
            end
            S_BIAS:
            begin
                i_next     = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                cmd.op        = (i_reg == '0) ? DP_BIAS_LD : DP_NOP;
                cmd.mac_issue = 1'b1;
                if (last_i) begin
                    state_next = S_DRAIN1;
                end else begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            S_DRAIN1:
            begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.op = DP_ACT_WB;
                if (!last_j) begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_BIAS;
                end else if (last_layer) begin
                    state_next = S_PMUL;
                end else begin
                    layer_next = layer_reg + LAY_W'(1);
                    j_next     = '0;
                    state_next = S_BIAS;
                end
            end
            S_PMUL:
            begin
                cmd.op     = DP_POS_MUL;
                state_next = S_PFIN;
            end
            S_PFIN:
            begin
                cmd.op = DP_POS_FIN;
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            layer_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign layer    = layer_reg;
    assign idx_i    = i_reg;
    assign idx_j    = j_reg;

endmodule

@@ rtl/core/mlp_key_position_predictor_core.sv @@
// Top level of the key position predictor.
// Depends on mkpp_pkg and instantiates mkpp_ctrl and mkpp_datapath.
//
// Usage. The input stream carries requests: tuser holds the command, tdata the
// layer, unit indices, coefficient and key. Weight and bias writes are taken
// while idle and give no result. A predict request gives one result on the output
// stream: tdata holds the position, tuser the saturation flag.
// A predict passes from acceptance to the result register through the key load,
// in log mode the logarithm (one leading-zero shift per cycle plus table
// lookup, interpolation and scaling by ln2), the normalization, the layer
// loops and the position scaling. The shared multiplier walks the weights one
// per cycle. Only one predict is in flight; the input is ready again as soon
// as the result is registered.
// A finished result waits in the output register while the receiver stalls;
// a following predict then holds in its last step until the register frees.
// Reset clears the configuration registers to their defaults and the control state;
// weights and biases must be written before the first predict. The user must write the
// configuration via cfg_we, cfg_index and cfg_data only while idle; not enforced.
module mlp_key_position_predictor_core
    import mkpp_pkg::*;
#(
    parameter int HIDDEN = 16,
    parameter int LAYERS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // layer_sel, from_unit, to_unit, coeff, key, pad
    input  logic [1:0]            s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // position
    output logic                  m_tuser,   // saturated
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int LAY_W = $clog2(LAYERS + 1);
    localparam int IDX_W = $clog2(HIDDEN + 1);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [LAY_W-1:0] layer;
    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;
    logic             in_fire;
    cmd_t             in_cmd;
    logic [31:0]      position;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_fire = s_tvalid && s_tready;
    assign m_tdata = position;

    mkpp_ctrl #(
        .HIDDEN (HIDDEN),
        .LAYERS (LAYERS),
        .LAY_W  (LAY_W),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (in_cmd),
        .status   (status),
        .cmd      (cmd),
        .layer    (layer),
        .idx_i    (idx_i),
        .idx_j    (idx_j)
    );

    mkpp_datapath #(
        .HIDDEN (HIDDEN),
        .LAYERS (LAYERS),
        .LAY_W  (LAY_W),
        .IDX_W  (IDX_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .in_cmd        (in_cmd),
        .in_layer      (s_tdata[2:0]),
        .in_from       (s_tdata[8:3]),
        .in_to         (s_tdata[14:9]),
        .in_coeff      (s_tdata[46:15]),
        .in_key        (s_tdata[78:47]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .layer         (layer),
        .idx_i         (idx_i),
        .idx_j         (idx_j),
        .status        (status),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_position  (position),
        .out_saturated (m_tuser)
    );

endmodule
